// File: design/xcs_pkg.sv
// Package for the XMODEM-CRC sender: protocol characters, register indexes,
// the result beat type and the CRC-16 and boot text functions.
// Used by the top level and the engine; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package xcs_pkg;

  localparam int BLOCK_BYTES_DEF = 128;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTE     = 1'd1;

  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [7:0] PAD_BYTE_RST     = 8'h00;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_START = 8'h43;

  localparam logic [2:0] REQ_RX_BYTE   = 3'd0;
  localparam logic [2:0] REQ_DATA_BYTE = 3'd1;
  localparam logic [2:0] REQ_END_DATA  = 3'd2;
  localparam logic [2:0] REQ_TICK      = 3'd3;
  localparam logic [2:0] REQ_RESTART   = 3'd4;

  localparam logic [1:0] KIND_TX       = 2'd0;
  localparam logic [1:0] KIND_CONSOLE  = 2'd1;
  localparam logic [1:0] KIND_FAILED   = 2'd2;
  localparam logic [1:0] KIND_COMPLETE = 2'd3;

  localparam logic [2:0] BOOT_LAST_IDX = 3'd6;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // One byte of CRC-16 with polynomial 0x1021, processed MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] boot_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h58;
      3'd2:    ch = 8'h42;
      3'd3:    ch = 8'h4F;
      3'd4:    ch = 8'h4F;
      3'd5:    ch = 8'h54;
      default: ch = 8'h24;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: design/xmodem_crc_sender.sv
// XMODEM-CRC sender top level: request, configuration and result registers
// around the block store RAM and the protocol engine. Uses xcs_pkg.
// Request beats pass the request register, result beats the output register.
// Throughput: one request beat per cycle while the result side takes beats; a stalled
// result beat holds the request register, so the input stalls in the same cycle.
// Reset clears control state, sets max_attempts to 3 and pad_byte to 0; no RAM clear.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_crc_sender #(
  parameter int BLOCK_BYTES = xcs_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [2:0]                     in_req_type,
  input  wire logic [7:0]                     in_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [1:0]                     out_kind,
  output logic      [7:0]                     out_byte,
  output logic                                out_frame_last,
  input  wire logic                           cfg_we,
  input  wire logic [xcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [xcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(BLOCK_BYTES);

  logic             req_vld_r;
  logic [2:0]       req_type_r;
  logic [7:0]       req_byte_r;
  logic             advance;
  logic             in_accept;
  logic [3:0]       max_att_r;
  logic [7:0]       pad_r;
  logic             out_vld_r, out_vld_nxt;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic [7:0]       rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  xcs_pkg::result_t res;

  assign advance   = req_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = req_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_vld_nxt = advance ? res.valid : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      max_att_r <= xcs_pkg::MAX_ATTEMPTS_RST;
      pad_r     <= xcs_pkg::PAD_BYTE_RST;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_accept) begin
        req_vld_r <= 1'b1;
      end else if (advance) begin
        req_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          xcs_pkg::CFG_MAX_ATTEMPTS: max_att_r <= cfg_wdata[3:0];
          xcs_pkg::CFG_PAD_BYTE:     pad_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type_r <= in_req_type;
      req_byte_r <= in_byte;
    end
    if (advance && res.valid) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.data;
      out_last_r <= res.last;
    end
  end

  xcs_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  xcs_engine #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .req         (req_type_r),
    .req_byte    (req_byte_r),
    .max_attempts(max_att_r),
    .pad_byte    (pad_r),
    .rd_data     (rd_data),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res         (res)
  );

  assign out_valid      = out_vld_r;
  assign out_kind       = out_kind_r;
  assign out_byte       = out_byte_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

// File: design/xcs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the data block of the XMODEM-CRC sender; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module xcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/xcs_engine.sv
// Protocol engine of the XMODEM-CRC sender: state machine, block counters,
// running CRC and the block store addressing. Uses xcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcs_engine #(
  parameter int BLOCK_BYTES = xcs_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [2:0]                     req,
  input  wire logic [7:0]                     req_byte,
  input  wire logic [3:0]                     max_attempts,
  input  wire logic [7:0]                     pad_byte,
  input  wire logic [7:0]                     rd_data,
  output logic      [$clog2(BLOCK_BYTES)-1:0] rd_addr,
  output logic                                wr_en,
  output logic      [$clog2(BLOCK_BYTES)-1:0] wr_addr,
  output logic      [7:0]                     wr_data,
  output xcs_pkg::result_t                    res
);

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int FW = $clog2(BLOCK_BYTES + 1);
  localparam int EW = $clog2(BLOCK_BYTES + 5);

  localparam logic [3:0] ST_LOAD       = 4'd0;
  localparam logic [3:0] ST_WAIT_C     = 4'd1;
  localparam logic [3:0] ST_SEND       = 4'd2;
  localparam logic [3:0] ST_WAIT_RESP  = 4'd3;
  localparam logic [3:0] ST_SEND_EOT   = 4'd4;
  localparam logic [3:0] ST_WAIT_FINAL = 4'd5;
  localparam logic [3:0] ST_PRINT      = 4'd6;
  localparam logic [3:0] ST_FAILED     = 4'd7;
  localparam logic [3:0] ST_BOOT       = 4'd8;

  localparam logic [EW-1:0] IDX_BLKNUM = EW'(1);
  localparam logic [EW-1:0] IDX_BLKINV = EW'(2);
  localparam logic [EW-1:0] IDX_DATA0  = EW'(3);
  localparam logic [EW-1:0] IDX_CRC_HI = EW'(3 + BLOCK_BYTES);
  localparam logic [FW-1:0] FILL_FULL  = FW'(BLOCK_BYTES);

  logic [3:0]    state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    blk_num_r, blk_num_nxt;
  logic          first_r, first_nxt;
  logic [3:0]    retry_r, retry_nxt;
  logic [EW-1:0] emit_r, emit_nxt;
  logic [15:0]   crc_r, crc_nxt;

  logic [EW-1:0] data_off;
  logic [EW-1:0] data_off_nxt;
  logic [7:0]    data_byte;
  logic [3:0]    retry_inc;
  logic [FW-1:0] fill_inc;

  assign data_off     = emit_r - IDX_DATA0;
  assign data_off_nxt = emit_nxt - IDX_DATA0;
  assign rd_addr      = data_off_nxt[AW-1:0];
  assign data_byte    = (data_off < EW'(fill_r)) ? rd_data : pad_byte;
  assign retry_inc    = retry_r + 4'd1;
  assign fill_inc     = fill_r + FW'(1);
  assign wr_addr      = fill_r[AW-1:0];
  assign wr_data      = req_byte;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    blk_num_nxt = blk_num_r;
    first_nxt   = first_r;
    retry_nxt   = retry_r;
    emit_nxt    = emit_r;
    crc_nxt     = crc_r;
    wr_en       = 1'b0;
    res         = '0;
    if (step) begin
      unique case (req)
        xcs_pkg::REQ_RX_BYTE: begin
          if (state_r == ST_WAIT_C) begin
            if (req_byte == xcs_pkg::CH_START) begin
              emit_nxt  = '0;
              state_nxt = ST_SEND;
            end
          end else if (state_r == ST_WAIT_RESP) begin
            if (req_byte == xcs_pkg::CH_ACK) begin
              retry_nxt   = '0;
              blk_num_nxt = blk_num_r + 8'd1;
              first_nxt   = 1'b0;
              fill_nxt    = '0;
              state_nxt   = ST_LOAD;
            end else begin
              retry_nxt = retry_inc;
              if (retry_inc >= max_attempts) begin
                state_nxt = ST_FAILED;
                res.valid = 1'b1;
                res.kind  = xcs_pkg::KIND_FAILED;
              end else begin
                emit_nxt  = '0;
                state_nxt = ST_SEND;
              end
            end
          end else if (state_r == ST_WAIT_FINAL) begin
            state_nxt = ST_PRINT;
            res.valid = 1'b1;
            res.kind  = xcs_pkg::KIND_COMPLETE;
          end else if (state_r == ST_PRINT) begin
            res.valid = 1'b1;
            res.kind  = xcs_pkg::KIND_CONSOLE;
            res.data  = req_byte;
          end
        end
        xcs_pkg::REQ_DATA_BYTE: begin
          if (state_r == ST_LOAD && fill_r < FILL_FULL) begin
            wr_en    = 1'b1;
            fill_nxt = fill_inc;
            if (fill_inc >= FILL_FULL) begin
              emit_nxt  = '0;
              state_nxt = first_r ? ST_WAIT_C : ST_SEND;
            end
          end
        end
        xcs_pkg::REQ_END_DATA: begin
          if (state_r == ST_LOAD) begin
            if (fill_r == '0 && !first_r) begin
              state_nxt = ST_SEND_EOT;
            end else begin
              emit_nxt  = '0;
              state_nxt = first_r ? ST_WAIT_C : ST_SEND;
            end
          end
        end
        xcs_pkg::REQ_TICK: begin
          if (state_r == ST_SEND) begin
            res.valid = 1'b1;
            res.kind  = xcs_pkg::KIND_TX;
            emit_nxt  = emit_r + EW'(1);
            priority if (emit_r == '0) begin
              crc_nxt  = '0;
              res.data = xcs_pkg::CH_SOH;
            end else if (emit_r == IDX_BLKNUM) begin
              res.data = blk_num_r;
            end else if (emit_r == IDX_BLKINV) begin
              res.data = ~blk_num_r;
            end else if (emit_r < IDX_CRC_HI) begin
              res.data = data_byte;
              crc_nxt  = xcs_pkg::crc16_byte(crc_r, data_byte);
            end else if (emit_r == IDX_CRC_HI) begin
              res.data = crc_r[15:8];
            end else begin
              res.data  = crc_r[7:0];
              res.last  = 1'b1;
              emit_nxt  = '0;
              state_nxt = ST_WAIT_RESP;
            end
          end else if (state_r == ST_SEND_EOT) begin
            state_nxt = ST_WAIT_FINAL;
            res.valid = 1'b1;
            res.kind  = xcs_pkg::KIND_TX;
            res.data  = xcs_pkg::CH_EOT;
            res.last  = 1'b1;
          end else if (state_r == ST_BOOT) begin
            res.valid = 1'b1;
            res.kind  = xcs_pkg::KIND_TX;
            if (emit_r >= EW'(xcs_pkg::BOOT_LAST_IDX)) begin
              res.data  = xcs_pkg::boot_char(xcs_pkg::BOOT_LAST_IDX);
              res.last  = 1'b1;
              emit_nxt  = '0;
              state_nxt = ST_LOAD;
            end else begin
              res.data = xcs_pkg::boot_char(emit_r[2:0]);
              emit_nxt = emit_r + EW'(1);
            end
          end
        end
        xcs_pkg::REQ_RESTART: begin
          if (state_r == ST_PRINT || state_r == ST_FAILED) begin
            fill_nxt    = '0;
            blk_num_nxt = 8'd1;
            first_nxt   = 1'b1;
            retry_nxt   = '0;
            emit_nxt    = '0;
            crc_nxt     = '0;
            state_nxt   = ST_BOOT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      fill_r    <= '0;
      blk_num_r <= 8'd1;
      first_r   <= 1'b1;
      retry_r   <= '0;
      emit_r    <= '0;
      crc_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      blk_num_r <= blk_num_nxt;
      first_r   <= first_nxt;
      retry_r   <= retry_nxt;
      emit_r    <= emit_nxt;
      crc_r     <= crc_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count exceeds the block size");

  a_send_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND |-> emit_r <= IDX_CRC_HI + EW'(1))
    else $error("frame index ran past the CRC low byte");

  a_boot_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BOOT |-> emit_r <= EW'(xcs_pkg::BOOT_LAST_IDX))
    else $error("boot string index out of range");

  a_fail_state: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == xcs_pkg::KIND_FAILED |=> state_r == ST_FAILED)
    else $error("failure reported without entering the failed state");

  a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.last |-> res.kind == xcs_pkg::KIND_TX)
    else $error("frame end flagged on an event beat");

endmodule

`default_nettype wire
